>>> rtl/bmc_pkg.sv
package bmc_pkg;

    // controller modes
    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_CALIB  = 3'd1,
        MODE_IDLE   = 3'd2,
        MODE_BAL    = 3'd3,
        MODE_FALLEN = 3'd4,
        MODE_ESTOP  = 3'd5
    } t_mode;

    // command codes
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_QUIT   = 2'd2;
    localparam logic [1:0] CMD_REINIT = 2'd3;

    // safety verdict codes
    localparam logic [2:0] VERDICT_OK         = 3'd0;
    localparam logic [2:0] VERDICT_TILT       = 3'd1;
    localparam logic [2:0] VERDICT_SATURATION = 3'd2;
    localparam logic [2:0] VERDICT_IMU_STALE  = 3'd3;
    localparam logic [2:0] VERDICT_OVERRUN    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_LOOP_PERIOD   = 3'd0;
    localparam logic [2:0] CFG_RECOVERY      = 3'd1;
    localparam logic [2:0] CFG_FALLEN_ANGLE  = 3'd2;
    localparam logic [2:0] CFG_FALLEN_WAIT   = 3'd3;
    localparam logic [2:0] CFG_CALIB_TIMEOUT = 3'd4;
    localparam logic [2:0] CFG_SETPOINT      = 3'd5;

    // configuration reset values
    localparam logic [9:0]         RST_LOOP_PERIOD   = 10'd10;
    localparam logic [14:0]        RST_RECOVERY      = 15'd1000;
    localparam logic [14:0]        RST_FALLEN_ANGLE  = 15'd4500;
    localparam logic [19:0]        RST_FALLEN_WAIT   = 20'd2000;
    localparam logic [19:0]        RST_CALIB_TIMEOUT = 20'd30000;
    localparam logic signed [12:0] RST_SETPOINT      = 13'sd0;

    // blink timing, ms
    localparam logic [6:0]  CALIB_HALF_MS   = 7'd50;
    localparam logic [10:0] IDLE_HALF_MS    = 11'd500;
    localparam logic [10:0] FALLEN_CYCLE_MS = 11'd1000;
    localparam logic [10:0] FALLEN_ON_MS    = 11'd100;
    localparam logic [10:0] FALLEN_ON2_LO   = 11'd200;
    localparam logic [10:0] FALLEN_ON2_HI   = 11'd300;
    localparam logic [10:0] ESTOP_ON_MS     = 11'd100;

    // reciprocal of 125 for a 28-bit dividend, exact over the whole range
    localparam int          RECIP125_SHIFT = 35;
    localparam logic [28:0] RECIP125       = 29'd274877907;
    localparam logic [27:0] DIV125         = 28'd125;
    // reciprocal of 25 for a dividend below 500
    localparam logic [14:0] RECIP25        = 15'd41;
    localparam logic [8:0]  DIV25          = 9'd25;

    localparam logic signed [16:0] ERR_MAX = 17'sd32767;
    localparam logic signed [16:0] ERR_MIN = -17'sd32768;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] pitch;
        logic [1:0]         command;
        logic               fully_calibrated;
        logic               gyro_calibrated;
        logic               auto_armed;
        logic [2:0]         safety_verdict;
        logic               reinit_ok;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         mode;
        logic               led_on;
        logic               control_tick;
        logic               motors_stop;
        logic               start_reset;
        logic               angle_pid_reset;
        logic               autoarm_reset;
        logic               reinit_attempt;
        logic               run_controller;
        logic signed [15:0] angle_error;
    } t_out_word;

    typedef struct packed {
        logic [2:0]  index;
        logic [19:0] value;
    } t_cfg_word;

    // blink levels per mode for the current time
    typedef struct packed {
        logic calib_on;
        logic idle_on;
        logic fallen_on;
        logic estop_on;
    } t_led_phase;

endpackage

>>> rtl/bmc_stream_if.sv
interface bmc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bmc_phase.sv
module bmc_phase
    import bmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_now,
    output t_led_phase  o_phase
);

    // stage 2: quotient of (now >> 4) / 125
    logic [56:0] w_prod;
    logic [20:0] r_q;
    logic [6:0]  r_m_lo;
    logic [3:0]  r_t_lo;

    assign w_prod = 57'(i_now[31:4]) * 57'(RECIP125);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= w_prod[RECIP125_SHIFT+20:RECIP125_SHIFT];
            r_m_lo <= i_now[10:4];
            r_t_lo <= i_now[3:0];
        end
    end

    // remainder fits in 7 bits, so only the low bits take part
    logic [27:0] w_q125;
    logic [6:0]  w_rem125;
    logic [10:0] w_r2000;
    logic [14:0] w_p41;

    assign w_q125   = 28'(r_q) * DIV125;
    assign w_rem125 = r_m_lo - w_q125[6:0];
    assign w_r2000  = {w_rem125, r_t_lo};
    assign w_p41    = 15'(w_r2000[10:2]) * RECIP25;

    logic [10:0] r_r2000;
    logic [14:0] r_p41;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2000 <= w_r2000;
            r_p41   <= w_p41;
        end
    end

    // stage 3: mod 100 and mod 1000 phases
    logic [8:0]  w_q25x;
    logic [4:0]  w_rem25;
    logic [6:0]  w_r100;
    logic [10:0] w_r1000;

    assign w_q25x  = 9'(r_p41[14:10]) * DIV25;
    assign w_rem25 = 5'(r_r2000[10:2] - w_q25x);
    assign w_r100  = {w_rem25, r_r2000[1:0]};
    assign w_r1000 = (r_r2000 >= FALLEN_CYCLE_MS) ? (r_r2000 - FALLEN_CYCLE_MS) : r_r2000;

    assign o_phase.calib_on  = (w_r100 >= CALIB_HALF_MS);
    assign o_phase.idle_on   = (w_r1000 >= IDLE_HALF_MS);
    assign o_phase.fallen_on = (w_r1000 < FALLEN_ON_MS) ||
                               ((w_r1000 >= FALLEN_ON2_LO) && (w_r1000 < FALLEN_ON2_HI));
    assign o_phase.estop_on  = (r_r2000 < ESTOP_ON_MS);

endmodule

>>> rtl/balance_robot_mode_controller.sv
// Mode and safety controller of a two-wheeled balancing robot. Each input word is one pass
// of the main loop (time, pitch, command and the flags of the calibration, auto-arm, safety
// and re-init units); each produces exactly one result word, in order. A pass is a control
// tick when the loop period or more has gone by since the last tick (modulo 2^32); on a tick
// the six-mode machine (init, calibrating, idle, balancing, fallen, estop) steps, with its
// calibration-timeout and fallen-wait timers, and raises the motor stop, reset and re-init
// pulses and the controller enable with the saturated angle error. The LED level follows
// the blink pattern of the mode held before the pass. Throughput is one word per clock;
// a result is presented once its word has passed the input register, two stages
// reducing the time to its 2000 ms phase by reciprocal multiplication, and the mode
// stage, whose state registers are read and written in the same cycle. Stalls on the
// output hold the whole pipe. Configuration writes are always accepted and take effect at
// once; they are meant to be made while no word is in flight.
module balance_robot_mode_controller
    import bmc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmc_stream_if.sink   i_in,
    bmc_stream_if.source o_out,
    bmc_stream_if.sink   i_cfg
);

    // ---------------------------------------------------------------- configuration
    logic [9:0]         r_loop_period;
    logic [14:0]        r_recovery_angle;
    logic [14:0]        r_fallen_angle;
    logic [19:0]        r_fallen_wait;
    logic [19:0]        r_calib_timeout;
    logic signed [12:0] r_setpoint;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_period    <= RST_LOOP_PERIOD;
            r_recovery_angle <= RST_RECOVERY;
            r_fallen_angle   <= RST_FALLEN_ANGLE;
            r_fallen_wait    <= RST_FALLEN_WAIT;
            r_calib_timeout  <= RST_CALIB_TIMEOUT;
            r_setpoint       <= RST_SETPOINT;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                CFG_LOOP_PERIOD:   r_loop_period    <= i_cfg.data.value[9:0];
                CFG_RECOVERY:      r_recovery_angle <= i_cfg.data.value[14:0];
                CFG_FALLEN_ANGLE:  r_fallen_angle   <= i_cfg.data.value[14:0];
                CFG_FALLEN_WAIT:   r_fallen_wait    <= i_cfg.data.value;
                CFG_CALIB_TIMEOUT: r_calib_timeout  <= i_cfg.data.value;
                CFG_SETPOINT:      r_setpoint       <= signed'(i_cfg.data.value[12:0]);
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- pipeline
    logic      r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;
    t_in_word  r_s1, r_s2, r_s3;
    t_out_word r_out;
    t_out_word n_out;

    // one enable for all stages: everything moves when the result register is free
    logic w_adv;
    assign w_adv      = !r_out_vld || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld  <= i_in.valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1  <= i_in.data;
            r_s2  <= r_s1;
            r_s3  <= r_s2;
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // blink phases of the time carried by the word in stage 3
    t_led_phase w_phase;

    bmc_phase u_phase (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_now   (r_s1.now_ms),
        .o_phase (w_phase)
    );

    // ---------------------------------------------------------------- mode state
    t_mode       r_mode, n_mode;
    logic [31:0] r_last_tick, n_last_tick;
    logic [31:0] r_calib_start, n_calib_start;
    logic        r_calib_valid, n_calib_valid;
    logic [31:0] r_fallen_start, n_fallen_start;
    logic        r_fallen_valid, n_fallen_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_INIT;
            r_last_tick    <= '0;
            r_calib_start  <= '0;
            r_calib_valid  <= 1'b0;
            r_fallen_start <= '0;
            r_fallen_valid <= 1'b0;
        end else begin
            r_mode         <= n_mode;
            r_last_tick    <= n_last_tick;
            r_calib_start  <= n_calib_start;
            r_calib_valid  <= n_calib_valid;
            r_fallen_start <= n_fallen_start;
            r_fallen_valid <= n_fallen_valid;
        end
    end

    // ---------------------------------------------------------------- stage 3 decisions
    logic [31:0]        w_now;
    logic signed [16:0] w_pitch_x;
    logic [16:0]        w_abs_pitch;
    logic               w_upright;
    logic               w_tilted;
    logic               w_tick;
    logic               w_fire;
    logic [31:0]        w_calib_ref, w_fallen_ref;
    logic               w_calib_tmo;
    logic               w_fallen_done;
    logic signed [16:0] w_err;
    logic signed [15:0] w_err_sat;
    logic               w_led;

    assign w_now       = r_s3.now_ms;
    assign w_pitch_x   = 17'(r_s3.pitch);
    assign w_abs_pitch = w_pitch_x[16] ? 17'(-w_pitch_x) : 17'(w_pitch_x);
    assign w_upright   = w_abs_pitch < {2'b00, r_recovery_angle};
    assign w_tilted    = w_abs_pitch > {2'b00, r_fallen_angle};
    assign w_tick      = (w_now - r_last_tick) >= {22'd0, r_loop_period};
    // state moves only when the word in stage 3 leaves for the result register
    assign w_fire      = r_s3_vld && w_adv;

    // a timer not yet running starts at this pass, so its elapsed time is zero
    assign w_calib_ref   = r_calib_valid ? r_calib_start : w_now;
    assign w_fallen_ref  = r_fallen_valid ? r_fallen_start : w_now;
    assign w_calib_tmo   = ((w_now - w_calib_ref) >= {12'd0, r_calib_timeout}) &&
                           r_s3.gyro_calibrated;
    assign w_fallen_done = (w_now - w_fallen_ref) >= {12'd0, r_fallen_wait};

    assign w_err     = 17'(r_setpoint) - 17'(r_s3.pitch);
    assign w_err_sat = (w_err > ERR_MAX) ? 16'sh7FFF :
                       (w_err < ERR_MIN) ? 16'sh8000 : w_err[15:0];

    // led follows the mode held before this pass
    always_comb begin
        case (r_mode)
            MODE_CALIB:  w_led = w_phase.calib_on;
            MODE_IDLE:   w_led = w_phase.idle_on;
            MODE_BAL:    w_led = 1'b1;
            MODE_FALLEN: w_led = w_phase.fallen_on;
            MODE_ESTOP:  w_led = w_phase.estop_on;
            default:     w_led = 1'b0;
        endcase
    end

    always_comb begin
        n_mode         = r_mode;
        n_last_tick    = r_last_tick;
        n_calib_start  = r_calib_start;
        n_calib_valid  = r_calib_valid;
        n_fallen_start = r_fallen_start;
        n_fallen_valid = r_fallen_valid;

        n_out                 = '0;
        n_out.led_on          = w_led;
        n_out.control_tick    = w_tick;

        if (w_tick) begin
            case (r_mode)
                MODE_CALIB: begin
                    if (!r_calib_valid) begin
                        n_calib_start = w_now;
                        n_calib_valid = 1'b1;
                    end
                    if ((r_s3.fully_calibrated || w_calib_tmo) && w_upright) begin
                        n_calib_valid       = 1'b0;
                        n_out.autoarm_reset = 1'b1;
                        n_mode              = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                    n_out.motors_stop = 1'b1;
                    if (r_s3.auto_armed || ((r_s3.command == CMD_START) && w_upright)) begin
                        n_out.start_reset = 1'b1;
                        n_mode            = MODE_BAL;
                    end else if (w_tilted) begin
                        n_out.autoarm_reset = 1'b1;
                        n_mode              = MODE_FALLEN;
                    end
                end
                MODE_BAL: begin
                    if (r_s3.safety_verdict != VERDICT_OK) begin
                        // unknown verdicts stop the motors but keep the mode
                        n_out.motors_stop = 1'b1;
                        if ((r_s3.safety_verdict == VERDICT_TILT) ||
                            (r_s3.safety_verdict == VERDICT_SATURATION)) begin
                            n_mode = MODE_FALLEN;
                        end else if ((r_s3.safety_verdict == VERDICT_IMU_STALE) ||
                                     (r_s3.safety_verdict == VERDICT_OVERRUN)) begin
                            n_mode = MODE_ESTOP;
                        end
                    end else if (r_s3.command == CMD_QUIT) begin
                        n_out.motors_stop   = 1'b1;
                        n_out.autoarm_reset = 1'b1;
                        n_mode              = MODE_IDLE;
                    end else begin
                        n_out.run_controller = 1'b1;
                        n_out.angle_error    = w_err_sat;
                    end
                end
                MODE_FALLEN: begin
                    n_out.motors_stop = 1'b1;
                    if (!r_fallen_valid) begin
                        n_fallen_start = w_now;
                        n_fallen_valid = 1'b1;
                    end
                    if (w_fallen_done && w_upright) begin
                        n_fallen_valid        = 1'b0;
                        n_out.angle_pid_reset = 1'b1;
                        n_out.autoarm_reset   = 1'b1;
                        n_mode                = MODE_IDLE;
                    end
                end
                default: begin
                    // init and estop wait for a re-init request
                    if (r_mode == MODE_ESTOP) begin
                        n_out.motors_stop = 1'b1;
                    end
                    if (r_s3.command == CMD_REINIT) begin
                        n_out.motors_stop    = 1'b1;
                        n_out.reinit_attempt = 1'b1;
                        if (r_s3.reinit_ok) begin
                            n_mode = MODE_CALIB;
                        end
                    end
                end
            endcase
        end

        n_out.mode = n_mode;

        if (!w_fire || !w_tick) begin
            n_mode         = r_mode;
            n_calib_start  = r_calib_start;
            n_calib_valid  = r_calib_valid;
            n_fallen_start = r_fallen_start;
            n_fallen_valid = r_fallen_valid;
        end else begin
            n_last_tick = w_now;
        end
    end

endmodule

>>> rtl/bmc_checker.sv
module bmc_checker
    import bmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    // mode of the last delivered word
    logic [2:0] r_last_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mode <= MODE_INIT;
        end else if (i_out_valid && i_out_ready) begin
            r_last_mode <= i_out_data.mode;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    a_mode_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.control_tick |-> i_out_data.mode == r_last_mode)
        else $error("mode changed on a pass without control tick");

    a_run_in_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.run_controller |->
            i_out_data.control_tick && (i_out_data.mode == MODE_BAL) &&
            !i_out_data.motors_stop)
        else $error("controller enabled outside balancing");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind balance_robot_mode_controller bmc_checker u_bmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> verif/balance_robot_mode_controller_tb.sv
`timescale 1ns / 100ps

import bmc_pkg::*;

// predicts the result word of every pass and checks the results against it in order
class mode_scoreboard;
    // register copies
    logic [9:0]         period_ms;
    logic [14:0]        upright_limit;
    logic [14:0]        fallen_limit;
    logic [19:0]        fallen_wait;
    logic [19:0]        calib_timeout;
    logic signed [12:0] setpoint;

    // mode machine and timer copies
    t_mode       mode;
    logic [31:0] last_tick;
    logic [31:0] calib_start;
    bit          calib_running;
    logic [31:0] fallen_start;
    bit          fallen_running;

    t_out_word   expected_words[$];
    int          mismatches;

    function new();
        period_ms      = RST_LOOP_PERIOD;
        upright_limit  = RST_RECOVERY;
        fallen_limit   = RST_FALLEN_ANGLE;
        fallen_wait    = RST_FALLEN_WAIT;
        calib_timeout  = RST_CALIB_TIMEOUT;
        setpoint       = RST_SETPOINT;
        mode           = MODE_INIT;
        last_tick      = '0;
        calib_start    = '0;
        calib_running  = 1'b0;
        fallen_start   = '0;
        fallen_running = 1'b0;
        mismatches     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [19:0] value);
        case (idx)
            CFG_LOOP_PERIOD:   period_ms = value[9:0];
            CFG_RECOVERY:      upright_limit = value[14:0];
            CFG_FALLEN_ANGLE:  fallen_limit = value[14:0];
            CFG_FALLEN_WAIT:   fallen_wait = value;
            CFG_CALIB_TIMEOUT: calib_timeout = value;
            CFG_SETPOINT:      setpoint = value[12:0];
            default: ;
        endcase
    endfunction

    // blink pattern of a mode at time t
    function bit blink_level(t_mode m, logic [31:0] t);
        logic [31:0] ph;
        ph = t % 1000;
        case (m)
            MODE_CALIB:  return ((t / 50) % 2) != 0;
            MODE_IDLE:   return ((t / 500) % 2) != 0;
            MODE_BAL:    return 1'b1;
            MODE_FALLEN: return (ph < 100) || (ph >= 200 && ph < 300);
            MODE_ESTOP:  return (t % 2000) < 100;
            default:     return 1'b0;
        endcase
    endfunction

    function void note_input(t_in_word w);
        t_out_word e;
        int        pitch;
        int        absp;
        int        err;
        bit        upright;
        bit        tick;
        bit        timed_out;
        pitch   = w.pitch;
        absp    = (pitch < 0) ? -pitch : pitch;
        upright = absp < int'(upright_limit);
        e       = '0;
        err     = 0;
        // led follows the mode held before this pass
        e.led_on = blink_level(mode, w.now_ms);
        tick = (w.now_ms - last_tick) >= period_ms;
        if (tick) begin
            last_tick = w.now_ms;
            case (mode)
                MODE_CALIB: begin
                    if (!calib_running) begin
                        calib_start   = w.now_ms;
                        calib_running = 1'b1;
                    end
                    timed_out = ((w.now_ms - calib_start) >= calib_timeout) && w.gyro_calibrated;
                    if ((w.fully_calibrated || timed_out) && upright) begin
                        calib_running   = 1'b0;
                        e.autoarm_reset = 1'b1;
                        mode            = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                    e.motors_stop = 1'b1;
                    if (w.auto_armed || (w.command == CMD_START && upright)) begin
                        e.start_reset = 1'b1;
                        mode          = MODE_BAL;
                    end else if (absp > int'(fallen_limit)) begin
                        e.autoarm_reset = 1'b1;
                        mode            = MODE_FALLEN;
                    end
                end
                MODE_BAL: begin
                    if (w.safety_verdict != VERDICT_OK) begin
                        e.motors_stop = 1'b1;
                        if (w.safety_verdict == VERDICT_TILT ||
                            w.safety_verdict == VERDICT_SATURATION) begin
                            mode = MODE_FALLEN;
                        end else if (w.safety_verdict == VERDICT_IMU_STALE ||
                                     w.safety_verdict == VERDICT_OVERRUN) begin
                            mode = MODE_ESTOP;
                        end
                    end else if (w.command == CMD_QUIT) begin
                        e.motors_stop   = 1'b1;
                        e.autoarm_reset = 1'b1;
                        mode            = MODE_IDLE;
                    end else begin
                        e.run_controller = 1'b1;
                        err = int'(setpoint) - pitch;
                        if (err > 32767) err = 32767;
                        if (err < -32768) err = -32768;
                    end
                end
                MODE_FALLEN: begin
                    e.motors_stop = 1'b1;
                    if (!fallen_running) begin
                        fallen_start   = w.now_ms;
                        fallen_running = 1'b1;
                    end
                    if (((w.now_ms - fallen_start) >= fallen_wait) && upright) begin
                        fallen_running    = 1'b0;
                        e.angle_pid_reset = 1'b1;
                        e.autoarm_reset   = 1'b1;
                        mode              = MODE_IDLE;
                    end
                end
                default: begin
                    if (mode == MODE_ESTOP) e.motors_stop = 1'b1;
                    if (w.command == CMD_REINIT) begin
                        e.motors_stop    = 1'b1;
                        e.reinit_attempt = 1'b1;
                        if (w.reinit_ok) mode = MODE_CALIB;
                    end
                end
            endcase
        end
        e.mode         = mode;
        e.control_tick = tick;
        e.angle_error  = err[15:0];
        expected_words.push_back(e);
    endfunction

    function void report(string field, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(t_out_word got);
        t_out_word e;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result word with none expected: mode %0d", got.mode);
            return;
        end
        e = expected_words.pop_front();
        if (got.mode !== e.mode) report("mode", e.mode, got.mode);
        if (got.led_on !== e.led_on) report("led_on", e.led_on, got.led_on);
        if (got.control_tick !== e.control_tick)
            report("control_tick", e.control_tick, got.control_tick);
        if (got.motors_stop !== e.motors_stop)
            report("motors_stop", e.motors_stop, got.motors_stop);
        if (got.start_reset !== e.start_reset)
            report("start_reset", e.start_reset, got.start_reset);
        if (got.angle_pid_reset !== e.angle_pid_reset)
            report("angle_pid_reset", e.angle_pid_reset, got.angle_pid_reset);
        if (got.autoarm_reset !== e.autoarm_reset)
            report("autoarm_reset", e.autoarm_reset, got.autoarm_reset);
        if (got.reinit_attempt !== e.reinit_attempt)
            report("reinit_attempt", e.reinit_attempt, got.reinit_attempt);
        if (got.run_controller !== e.run_controller)
            report("run_controller", e.run_controller, got.run_controller);
        if (got.angle_error !== e.angle_error)
            report("angle_error", e.angle_error, got.angle_error);
    endfunction
endclass

module balance_robot_mode_controller_tb;

    // generous bound, far above the slowest correct run
    localparam int CYCLE_LIMIT = 300000;

    // verdict codes the safety unit never should send
    localparam logic [2:0] VERDICT_SPARE_LO = 3'd5;
    localparam logic [2:0] VERDICT_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;

    bmc_stream_if #(.t_payload(t_in_word))  in_if ();
    bmc_stream_if #(.t_payload(t_out_word)) out_if ();
    bmc_stream_if #(.t_payload(t_cfg_word)) cfg_if ();

    balance_robot_mode_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    mode_scoreboard sb = new();

    int          src_idle_pct;
    int          snk_idle_pct;
    int          words_sent;
    int          cycle_count;
    logic [31:0] now_cursor;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver side: random back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // every accepted result word goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.data);
    end

    // run guard
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // offer one input word until it is taken; idling follows the run position
    task automatic send_word(t_in_word w);
        if (words_sent < 160) begin
            src_idle_pct = 33;
            snk_idle_pct = 87;
        end else if (words_sent < 320) begin
            src_idle_pct = 87;
            snk_idle_pct = 33;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(w);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drive_pass(logic [31:0] t, int pitch, logic [1:0] cmd, int full, int gyro,
                              int armed, logic [2:0] verdict, int rok);
        t_in_word w;
        w.now_ms           = t;
        w.pitch            = pitch[15:0];
        w.command          = cmd;
        w.fully_calibrated = full[0];
        w.gyro_calibrated  = gyro[0];
        w.auto_armed       = armed[0];
        w.safety_verdict   = verdict;
        w.reinit_ok        = rok[0];
        send_word(w);
    endtask

    // stop offering words and wait until every expected result is back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (sb.expected_words.size() != 0);
    endtask

    // leaves valid high so back-to-back writes follow without valid dropping between them
    task automatic write_register(logic [2:0] idx, logic [19:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= {idx, value};
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(logic [9:0] period, logic [14:0] upright, logic [14:0] fallen,
                                  logic [19:0] wait_ms, logic [19:0] timeout_ms,
                                  logic [12:0] target);
        drain_results();
        write_register(CFG_LOOP_PERIOD, {10'd0, period});
        write_register(CFG_RECOVERY, {5'd0, upright});
        write_register(CFG_FALLEN_ANGLE, {5'd0, fallen});
        write_register(CFG_FALLEN_WAIT, wait_ms);
        write_register(CFG_CALIB_TIMEOUT, timeout_ms);
        write_register(CFG_SETPOINT, {7'd0, target});
        cfg_if.valid <= 1'b0;
    endtask

    // upright pitch lies strictly inside the recovery angle, when there is such a pitch
    function automatic logic [15:0] pick_pitch(bit upright);
        int lim;
        int mag;
        lim = int'(sb.upright_limit) - 1;
        if (upright && lim >= 0) begin
            mag = $urandom_range(0, lim);
            return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
        end
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 36000)) - 18000);
    endfunction

    // next pass of the main loop, mostly shaped to move the current mode along
    function automatic t_in_word make_word();
        t_in_word    w;
        int          r;
        bit          noise;
        logic [31:0] span;
        noise = ($urandom_range(0, 99) < 15);
        r     = $urandom_range(0, 99);
        span  = (sb.mode == MODE_FALLEN) ? 32'(sb.fallen_wait) : 32'(sb.calib_timeout);

        // time: mostly one period apart, sometimes short, long or a jump anywhere
        if ((sb.mode == MODE_FALLEN || sb.mode == MODE_CALIB) && $urandom_range(0, 3) == 0)
            now_cursor += $urandom_range(0, 2 * span + 10);
        else if (r < 55)
            now_cursor += 32'(sb.period_ms) + $urandom_range(0, 3);
        else if (r < 75)
            now_cursor += $urandom_range(0, sb.period_ms);
        else if (r < 92)
            now_cursor += $urandom_range(0, 3000);
        else if (r < 97)
            now_cursor += $urandom_range(0, 2100000);
        else
            now_cursor = $urandom;

        w.now_ms           = now_cursor;
        w.pitch            = pick_pitch(1'b0);
        w.command          = 2'($urandom_range(0, 3));
        w.fully_calibrated = 1'($urandom_range(0, 1));
        w.gyro_calibrated  = 1'($urandom_range(0, 1));
        w.auto_armed       = 1'($urandom_range(0, 1));
        w.safety_verdict   = 3'($urandom_range(0, 7));
        w.reinit_ok        = 1'($urandom_range(0, 1));

        if (!noise) begin
            case (sb.mode)
                MODE_INIT, MODE_ESTOP: begin
                    if ($urandom_range(0, 9) < 7) w.command = CMD_REINIT;
                    w.reinit_ok = ($urandom_range(0, 9) < 6);
                end
                MODE_CALIB: begin
                    w.fully_calibrated = ($urandom_range(0, 9) < 4);
                    w.gyro_calibrated  = ($urandom_range(0, 9) < 6);
                    w.pitch            = pick_pitch($urandom_range(0, 9) < 8);
                end
                MODE_IDLE: begin
                    w.auto_armed = ($urandom_range(0, 99) < 25);
                    if ($urandom_range(0, 9) < 3) w.command = CMD_START;
                    w.pitch = pick_pitch($urandom_range(0, 9) < 6);
                end
                MODE_BAL: begin
                    w.safety_verdict = ($urandom_range(0, 99) < 80) ? VERDICT_OK
                                                                   : 3'($urandom_range(1, 7));
                    if ($urandom_range(0, 9) == 0)
                        w.command = CMD_QUIT;
                    else
                        w.command = ($urandom_range(0, 1) != 0) ? CMD_NONE : CMD_START;
                end
                MODE_FALLEN: begin
                    w.pitch = pick_pitch($urandom_range(0, 9) < 7);
                end
                default: ;
            endcase
        end
        return w;
    endfunction

    // random passes; at pause_at the sender holds until everything is back
    task automatic run_random(int count, int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain_results();
            send_word(make_word());
        end
    endtask

    initial begin
        // known values on every input from time zero
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        now_cursor   = '0;
        words_sent   = 0;
        src_idle_pct = 33;
        snk_idle_pct = 87;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk: period 1 so every later pass ticks, timers at zero
        apply_settings(10'd1, 15'd1000, 15'd4500, 20'd0, 20'd0, -13'sd4096);
        // no time has gone by since reset, so the first pass is not a tick
        drive_pass(32'd0, 0, CMD_REINIT, 0, 0, 0, VERDICT_OK, 1);
        // failed re-init stays in init, start is ignored there
        drive_pass(32'd1, 0, CMD_REINIT, 0, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd2, 0, CMD_START, 0, 0, 0, VERDICT_OK, 1);
        drive_pass(32'd3, 0, CMD_REINIT, 0, 0, 0, VERDICT_OK, 1);
        // calibrated but tilted, then gyro-only through the zero timeout
        drive_pass(32'd4, 5000, CMD_NONE, 1, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd5, 0, CMD_NONE, 0, 1, 0, VERDICT_OK, 0);
        // start while tilted is ignored, most negative pitch falls over
        drive_pass(32'd6, 2000, CMD_START, 0, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd7, -32768, CMD_NONE, 0, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd8, 0, CMD_NONE, 0, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd9, -999, CMD_START, 0, 0, 0, VERDICT_OK, 0);
        // angle error saturates low with the lowest setpoint
        drive_pass(32'd10, 32767, CMD_NONE, 0, 0, 0, VERDICT_OK, 0);
        // undefined verdicts stop the motors but keep balancing mode
        drive_pass(32'd11, 100, CMD_NONE, 0, 0, 0, VERDICT_SPARE_LO, 0);
        drive_pass(32'd12, 100, CMD_NONE, 0, 0, 0, VERDICT_SPARE_HI, 0);
        drive_pass(32'd13, -500, CMD_QUIT, 0, 0, 0, VERDICT_OK, 0);
        // each fault verdict from balancing
        drive_pass(32'd14, 0, CMD_NONE, 0, 0, 1, VERDICT_OK, 0);
        drive_pass(32'd15, 0, CMD_NONE, 0, 0, 0, VERDICT_TILT, 0);
        drive_pass(32'd16, 0, CMD_NONE, 0, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd17, 0, CMD_NONE, 0, 0, 1, VERDICT_OK, 0);
        drive_pass(32'd18, 0, CMD_NONE, 0, 0, 0, VERDICT_SATURATION, 0);
        drive_pass(32'd19, 0, CMD_NONE, 0, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd20, 0, CMD_NONE, 0, 0, 1, VERDICT_OK, 0);
        drive_pass(32'd21, 0, CMD_NONE, 0, 0, 0, VERDICT_IMU_STALE, 0);
        // re-init out of estop, back up to balancing, overrun
        drive_pass(32'd22, 0, CMD_REINIT, 0, 0, 0, VERDICT_OK, 1);
        drive_pass(32'd23, 0, CMD_NONE, 1, 0, 0, VERDICT_OK, 0);
        drive_pass(32'd24, 0, CMD_NONE, 0, 0, 1, VERDICT_OK, 0);
        drive_pass(32'd25, 0, CMD_NONE, 0, 0, 0, VERDICT_OVERRUN, 0);
        now_cursor = 32'd25;

        // reset values, with a mid-phase hold of the sender
        apply_settings(RST_LOOP_PERIOD, RST_RECOVERY, RST_FALLEN_ANGLE, RST_FALLEN_WAIT,
                       RST_CALIB_TIMEOUT, RST_SETPOINT);
        run_random(100, 50);
        // zero period, widest recovery and zero fallen angle, longest timers, highest setpoint
        apply_settings(10'd0, 15'h7FFF, 15'd0, 20'hFFFFF, 20'hFFFFF, 13'sd4095);
        run_random(60, -1);
        // slowest period, nothing upright, zero timers, lowest setpoint
        apply_settings(10'h3FF, 15'd0, 15'h7FFF, 20'd0, 20'd0, -13'sd4096);
        run_random(50, -1);
        // usual operating ranges
        for (int p = 0; p < 4; p++) begin
            apply_settings(10'($urandom_range(1, 50)), 15'($urandom_range(500, 3000)),
                           15'($urandom_range(2000, 8000)), 20'($urandom_range(0, 5000)),
                           20'($urandom_range(0, 10000)),
                           13'(int'($urandom_range(0, 6000)) - 3000));
            run_random(60, -1);
        end

        drain_results();
        // keep the clock running to catch any stray result word
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bmc_pkg.sv
rtl/bmc_stream_if.sv
rtl/bmc_phase.sv
rtl/balance_robot_mode_controller.sv
rtl/bmc_checker.sv
verif/balance_robot_mode_controller_tb.sv
